// File: rtl/core/drive_sim_frame_parser_assert.svh
// assertion macros for the drive simulator frame parser
`ifndef DRIVE_SIM_FRAME_PARSER_ASSERT_SVH
`define DRIVE_SIM_FRAME_PARSER_ASSERT_SVH

// clocked property, masked while in reset
`define DSFP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every edge
`define DSFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/core/dsfp_pkg.sv
// shared types and constants of the drive simulator frame parser
`default_nettype none

package dsfp_pkg;

    localparam int unsigned CNT_W = 3;

    localparam logic [7:0]       START_BYTE  = 8'd2;
    localparam logic [CNT_W-1:0] TACHO_POS   = 3'd2;
    localparam logic [CNT_W-1:0] SPEED_POS   = 3'd3;
    localparam logic [15:0]      TACHO_SCALE = 16'd100;

    typedef struct packed {
        logic       valid;
        logic [7:0] rpm;
        logic [7:0] vel;
    } frame_evt_t;

endpackage

`default_nettype wire

// File: rtl/core/drive_sim_frame_parser.sv
// top level of the drive simulator frame parser
//
//  channel  | dir | word
//  s_axis   | in  | one received serial byte
//  m_axis   | out | tacho, speed and change flags of a good frame
//
// one byte per cycle while s_tready is high; a result passes from the checksum byte
// through the collector event register and then the output register
// rst_n clears the collector to idle and the stored values to minus one
// s_tready drops only while a result waits in the output register and a
// changed frame is queued behind it
`default_nettype none

module drive_sim_frame_parser
    import dsfp_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 7
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [15:0] tacho_value, [24:16] speed_value,
                                        // [25] tacho_changed, [26] speed_changed
);

    frame_evt_t         evt;
    logic               advance;
    logic               in_fire;
    logic signed [15:0] tacho_value;
    logic signed [8:0]  speed_value;
    logic               tacho_changed;
    logic               speed_changed;

    assign s_tready = advance;
    assign in_fire  = s_tvalid && advance;

    dsfp_collect #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_collect (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .rx_byte (s_tdata),
        .advance (advance),
        .evt     (evt)
    );

    dsfp_update u_update (
        .clk           (clk),
        .rst_n         (rst_n),
        .evt           (evt),
        .advance       (advance),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .tacho_value   (tacho_value),
        .speed_value   (speed_value),
        .tacho_changed (tacho_changed),
        .speed_changed (speed_changed)
    );

    assign m_tdata = {5'd0, speed_changed, tacho_changed, speed_value, tacho_value};

endmodule

`default_nettype wire

// File: rtl/core/dsfp_collect.sv
// frame collector: start detect, byte count, running sum, checksum compare
`default_nettype none

module dsfp_collect
    import dsfp_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 7
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_fire,
    input  wire logic [7:0] rx_byte,
    input  wire logic       advance,
    output frame_evt_t      evt
);

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(FRAME_BYTES);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       rpm_reg, rpm_next;
    logic [7:0]       vel_reg, vel_next;
    frame_evt_t       evt_reg, evt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        sum_next = sum_reg;
        rpm_next = rpm_reg;
        vel_next = vel_reg;
        evt_next = evt_reg;
        if (advance)
        begin
            evt_next.valid = 1'b0;
        end
        if (in_fire)
        begin
            if (cnt_reg == '0)
            begin
                if (rx_byte == START_BYTE)
                begin
                    sum_next = rx_byte;
                    cnt_next = CNT_W'(1);
                end
            end
            else if (cnt_reg < LAST_CNT)
            begin
                if (cnt_reg == TACHO_POS)
                begin
                    rpm_next = rx_byte;
                end
                if (cnt_reg == SPEED_POS)
                begin
                    vel_next = rx_byte;
                end
                sum_next = sum_reg + rx_byte;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            else
            begin
                cnt_next = '0;
                sum_next = '0;
                evt_next.valid = (rx_byte == sum_reg);
                evt_next.rpm   = rpm_reg;
                evt_next.vel   = vel_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            rpm_reg <= '0;
            vel_reg <= '0;
            evt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            sum_reg <= sum_next;
            rpm_reg <= rpm_next;
            vel_reg <= vel_next;
            evt_reg <= evt_next;
        end
    end

    assign evt = evt_reg;

endmodule

`default_nettype wire

// File: rtl/core/dsfp_update.sv
// value scaling, change detection against stored values, output register
`default_nettype none

module dsfp_update
    import dsfp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire frame_evt_t   evt,
    output logic              advance,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic signed [15:0] tacho_value,
    output logic signed [8:0]  speed_value,
    output logic              tacho_changed,
    output logic              speed_changed
);

    logic [15:0] last_tacho_reg;
    logic [8:0]  last_speed_reg;
    logic        out_valid_reg;
    logic [15:0] tacho_reg;
    logic [8:0]  speed_reg;
    logic        tc_reg;
    logic        sc_reg;

    logic [15:0] tacho;
    logic [8:0]  speed;
    logic        tc;
    logic        sc;
    logic        emit;

    always_comb
    begin
        tacho   = ({8'd0, evt.rpm} * TACHO_SCALE) - TACHO_SCALE;
        speed   = {1'b0, evt.vel} - 9'd1;
        tc      = (tacho != last_tacho_reg);
        sc      = (speed != last_speed_reg);
        emit    = evt.valid && (tc || sc);
        advance = !emit || !out_valid_reg || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_tacho_reg <= '1;
            last_speed_reg <= '1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (evt.valid && advance)
            begin
                last_tacho_reg <= tacho;
                last_speed_reg <= speed;
            end
            if (emit && advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && advance)
        begin
            tacho_reg <= tacho;
            speed_reg <= speed;
            tc_reg    <= tc;
            sc_reg    <= sc;
        end
    end

    assign out_valid     = out_valid_reg;
    assign tacho_value   = $signed(tacho_reg);
    assign speed_value   = $signed(speed_reg);
    assign tacho_changed = tc_reg;
    assign speed_changed = sc_reg;

endmodule

`default_nettype wire

// File: rtl/core/dsfp_checker.sv
// port-level checker for the drive simulator frame parser, bound to the top
`default_nettype none

`include "drive_sim_frame_parser_assert.svh"

module dsfp_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    logic in_stall;
    logic tacho_ok;

    assign in_stall = s_tvalid && !s_tready;
    assign tacho_ok = ($signed(m_tdata[15:0]) >= -16'sd100)
                   && ($signed(m_tdata[15:0]) <= 16'sd25400);

    `DSFP_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word not held")
    `DSFP_ASSERT_IMP(a_flag, m_tvalid, m_tdata[25] || m_tdata[26], "word with no change flag")
    `DSFP_ASSERT_IMP(a_range, m_tvalid, tacho_ok, "tacho out of range")
    `DSFP_ASSERT_IMP(a_stall, in_stall, m_tvalid && !m_tready, "stall without backpressure")

endmodule

bind drive_sim_frame_parser dsfp_checker u_dsfp_checker (.*);

`default_nettype wire

// File: sim/tb_drive_sim_frame_parser.sv
// self-checking testbench of the drive simulator frame parser
`default_nettype none

module tb_drive_sim_frame_parser;
    import dsfp_pkg::*;

    localparam int FRAME_LEN   = 7;
    localparam int BYTE_TARGET = 1650;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 20;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;

    // one dashboard word as it leaves on m_tdata, lowest field declared last
    typedef struct packed {
        logic [4:0]  pad;
        logic        speed_chg;
        logic        tacho_chg;
        logic [8:0]  speed;
        logic [15:0] tacho;
    } dash_word_t;

    class dash_scoreboard;
        logic [2:0]  count;
        logic [7:0]  sum;
        logic [7:0]  rpm;
        logic [7:0]  vel;
        logic [15:0] last_tacho;
        logic [8:0]  last_speed;
        dash_word_t  dash_q[$];
        int          errors;
        int          words_checked;
        int          good_frames;
        int          bad_frames;
        int          quiet_frames;

        function new();
            count         = '0;
            sum           = '0;
            rpm           = '0;
            vel           = '0;
            last_tacho    = '1;
            last_speed    = '1;
            errors        = 0;
            words_checked = 0;
            good_frames   = 0;
            bad_frames    = 0;
            quiet_frames  = 0;
        endfunction

        // advance the parser state by one accepted byte
        function void note_byte(logic [7:0] b);
            dash_word_t w;
            logic [15:0] tacho;
            logic [8:0]  speed;
            if (count == 0)
            begin
                if (b == START_BYTE)
                begin
                    sum   = b;
                    count = 3'd1;
                end
            end
            else if (int'(count) < FRAME_LEN)
            begin
                if (count == TACHO_POS)
                    rpm = b;
                if (count == SPEED_POS)
                    vel = b;
                sum   = sum + b;
                count = count + 3'd1;
            end
            else
            begin
                count = '0;
                if (b == sum)
                begin
                    good_frames++;
                    tacho = {8'd0, rpm} * TACHO_SCALE - TACHO_SCALE;
                    speed = {1'b0, vel} - 9'd1;
                    w.pad       = '0;
                    w.tacho     = tacho;
                    w.speed     = speed;
                    w.tacho_chg = (tacho != last_tacho);
                    w.speed_chg = (speed != last_speed);
                    last_tacho  = tacho;
                    last_speed  = speed;
                    if (w.tacho_chg || w.speed_chg)
                        dash_q = {dash_q, w};
                    else
                        quiet_frames++;
                end
                else
                    bad_frames++;
                sum = '0;
            end
        endfunction

        function void flag(string what, logic [31:0] exp_v, logic [31:0] act_v);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("mismatch %0s: expected %h, got %h", what, exp_v, act_v);
        endfunction

        function void check_word(logic [31:0] data);
            dash_word_t got;
            dash_word_t exp_w;
            got = dash_word_t'(data);
            words_checked++;
            if (dash_q.size() == 0)
            begin
                flag("unexpected word", '0, data);
                return;
            end
            exp_w = dash_q.pop_front();
            if (got.tacho != exp_w.tacho)
                flag("tacho_value", 32'(exp_w.tacho), 32'(got.tacho));
            if (got.speed != exp_w.speed)
                flag("speed_value", 32'(exp_w.speed), 32'(got.speed));
            if (got.tacho_chg != exp_w.tacho_chg)
                flag("tacho_changed", 32'(exp_w.tacho_chg), 32'(got.tacho_chg));
            if (got.speed_chg != exp_w.speed_chg)
                flag("speed_changed", 32'(exp_w.speed_chg), 32'(got.speed_chg));
            if (got.pad != exp_w.pad)
                flag("padding bits", 32'(exp_w.pad), 32'(got.pad));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    dash_scoreboard sb;
    bit  tx_gaps;
    bit  quiet;
    bit  hold_req;
    int  bytes_sent;
    int  frames_sent;
    int  cycle_count;
    int  input_stalls;
    logic [7:0] prev_rpm;
    logic [7:0] prev_vel;

    drive_sim_frame_parser #(
        .FRAME_BYTES(FRAME_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (s_tvalid && !s_tready)
            input_stalls++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    // result side: random stall bursts, one long hold on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    task automatic idle_in(input int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        s_tdata  = 8'($urandom);
        repeat (n - 1) @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps && !quiet && $urandom_range(0, 6) == 0)
            idle_in($urandom_range(1, 7));
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] rpm, input logic [7:0] vel,
                              input bit bad_sum, input bit start_inside);
        logic [7:0] fb [FRAME_LEN+1];
        logic [7:0] acc;
        fb[0] = START_BYTE;
        for (int i = 1; i < FRAME_LEN; i++)
            fb[i] = 8'($urandom);
        if (start_inside)
        begin
            fb[1] = START_BYTE;
            fb[FRAME_LEN-1] = START_BYTE;
        end
        fb[TACHO_POS] = rpm;
        fb[SPEED_POS] = vel;
        acc = '0;
        for (int i = 0; i < FRAME_LEN; i++)
            acc = acc + fb[i];
        fb[FRAME_LEN] = bad_sum ? (acc ^ 8'($urandom_range(1, 255))) : acc;
        for (int i = 0; i <= FRAME_LEN; i++)
            send_byte(fb[i]);
        frames_sent++;
        prev_rpm = rpm;
        prev_vel = vel;
    endtask

    function automatic logic [7:0] pick_val();
        logic [7:0] v;
        case ($urandom_range(0, 7))
            0:       v = 8'd0;
            1:       v = 8'd1;
            2:       v = 8'd255;
            default: v = 8'($urandom);
        endcase
        return v;
    endfunction

    task automatic drain();
        while (sb.dash_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_frame();
        logic [7:0] rpm;
        logic [7:0] vel;
        int kind;
        rpm  = prev_rpm;
        vel  = prev_vel;
        kind = $urandom_range(0, 9);
        if (kind >= 3 && kind <= 4)
            rpm = pick_val();
        else if (kind >= 5 && kind <= 6)
            vel = pick_val();
        else if (kind >= 7)
        begin
            rpm = pick_val();
            vel = pick_val();
        end
        // stray bytes and cut-off frames between frames
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        if ($urandom_range(0, 19) == 0)
        begin
            send_byte(START_BYTE);
            repeat ($urandom_range(1, FRAME_LEN - 2)) send_byte(8'($urandom));
        end
        send_frame(rpm, vel, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0);
    endtask

    initial
    begin
        sb           = new();
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        tx_gaps      = 1'b1;
        quiet        = 1'b0;
        hold_req     = 1'b0;
        bytes_sent   = 0;
        frames_sent  = 0;
        cycle_count  = 0;
        input_stalls = 0;
        prev_rpm     = '0;
        prev_vel     = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: noise while idle, extreme values, start byte as data,
        // unchanged repeat, bad checksum
        send_byte(8'd255);
        send_byte(8'd0);
        send_frame(8'd0, 8'd255, 1'b0, 1'b1);
        send_frame(8'd0, 8'd255, 1'b0, 1'b0);
        send_frame(8'd255, 8'd0, 1'b1, 1'b0);
        drain();

        // random frames, gaps switched on and off in stretches
        while (bytes_sent < BYTE_TARGET)
        begin
            if (frames_sent % 16 == 0)
                tx_gaps = ($urandom_range(0, 3) != 0);
            if (bytes_sent > (BYTE_TARGET * 4) / 5)
                quiet = 1'b1;
            if (frames_sent == 60)
            begin
                // long result stall while changing frames keep coming
                hold_req = 1'b1;
                for (int i = 0; i < 8; i++)
                    send_frame(8'(i + 10), 8'(i * 3), 1'b0, 1'b0);
            end
            else if (frames_sent == 120)
            begin
                drain();
                random_frame();
            end
            else
                random_frame();
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        drain();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.dash_q.size() != 0)
        begin
            sb.errors++;
            $display("%0d expected words never arrived", sb.dash_q.size());
        end

        $display("sent %0d bytes in %0d frames: %0d good, %0d bad checksum, %0d unchanged",
                 bytes_sent, frames_sent, sb.good_frames, sb.bad_frames, sb.quiet_frames);
        $display("checked %0d result words, %0d input stall cycles, %0d mismatches",
                 sb.words_checked, input_stalls, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
